/* hw/rtl/psch_pkg.sv */
// ----------------------------------------------------------------------------
// psch_pkg
// Types and constants shared by the priority scheduler modules.
// ----------------------------------------------------------------------------
package psch_pkg;

    localparam int TIME_W = 24;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  priority_req;
    } cmd_t;

    typedef struct packed {
        logic [3:0]        job_index;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              idle_before;
        logic              saturated;
        logic              table_empty;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
    } entry_t;

endpackage

/* hw/rtl/psch_ram.sv */
// ----------------------------------------------------------------------------
// psch_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module psch_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/psch_pick.sv */
// ----------------------------------------------------------------------------
// psch_pick
// Running selection over one table scan: best arrived job and best job of
// the earliest pending arrival.
// ----------------------------------------------------------------------------
module psch_pick #(
    parameter int MAX_JOBS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        eval,
    input  logic [$clog2(MAX_JOBS)-1:0] idx,
    input  psch_pkg::entry_t            ent,
    input  logic                        served,
    input  logic [psch_pkg::TIME_W-1:0] now,
    output logic [$clog2(MAX_JOBS)-1:0] sel_idx,
    output psch_pkg::entry_t            sel_ent,
    output logic                        sel_idle
);
    import psch_pkg::*;

    localparam int AW = $clog2(MAX_JOBS);

    logic          arr_found_reg;
    logic          arr_found_next;
    logic [AW-1:0] arr_idx_reg;
    logic [AW-1:0] arr_idx_next;
    entry_t        arr_ent_reg;
    entry_t        arr_ent_next;
    logic          ear_found_reg;
    logic          ear_found_next;
    logic [AW-1:0] ear_idx_reg;
    logic [AW-1:0] ear_idx_next;
    entry_t        ear_ent_reg;
    entry_t        ear_ent_next;

    logic eligible;
    logic arrived;
    logic take_arr;
    logic take_ear;

    assign eligible = eval && !served;
    assign arrived  = {{(TIME_W-16){1'b0}}, ent.arrival} <= now;

    assign take_arr = eligible && arrived &&
                      (!arr_found_reg || (ent.prio < arr_ent_reg.prio) ||
                       ((ent.prio == arr_ent_reg.prio) &&
                        (ent.arrival < arr_ent_reg.arrival)));

    assign take_ear = eligible &&
                      (!ear_found_reg || (ent.arrival < ear_ent_reg.arrival) ||
                       ((ent.arrival == ear_ent_reg.arrival) &&
                        (ent.prio < ear_ent_reg.prio)));

    always_comb
    begin
        arr_found_next = arr_found_reg;
        arr_idx_next   = arr_idx_reg;
        arr_ent_next   = arr_ent_reg;
        ear_found_next = ear_found_reg;
        ear_idx_next   = ear_idx_reg;
        ear_ent_next   = ear_ent_reg;
        if (clear)
        begin
            arr_found_next = 1'b0;
            ear_found_next = 1'b0;
        end
        else
        begin
            if (take_arr)
            begin
                arr_found_next = 1'b1;
                arr_idx_next   = idx;
                arr_ent_next   = ent;
            end
            if (take_ear)
            begin
                ear_found_next = 1'b1;
                ear_idx_next   = idx;
                ear_ent_next   = ent;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arr_found_reg <= 1'b0;
            ear_found_reg <= 1'b0;
        end
        else
        begin
            arr_found_reg <= arr_found_next;
            ear_found_reg <= ear_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arr_idx_reg <= arr_idx_next;
        arr_ent_reg <= arr_ent_next;
        ear_idx_reg <= ear_idx_next;
        ear_ent_reg <= ear_ent_next;
    end

    assign sel_idle = !arr_found_reg;
    assign sel_idx  = arr_found_reg ? arr_idx_reg : ear_idx_reg;
    assign sel_ent  = arr_found_reg ? arr_ent_reg : ear_ent_reg;

endmodule

/* hw/rtl/nonpreemptive_priority_scheduler.sv */
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// Non-preemptive priority scheduler over a RAM-held job table.
// ----------------------------------------------------------------------------
// A load item stores a job in the next free table slot; loads beyond
// MAX_JOBS are dropped. A run item with n stored jobs produces n result
// items, each after one full scan of the table through the RAM read port
// followed by the ST_FIN, ST_TURN and ST_PUSH states, which compute finish,
// turnaround and waiting time and hand the result to the output register.
// A run on an empty table gives one empty result. The table is cleared
// when the last result of a run is handed to the output register.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler #(
    parameter int MAX_JOBS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  psch_pkg::cmd_t  cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output psch_pkg::res_t  res
);
    import psch_pkg::*;

    localparam int AW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int EW = $bits(entry_t);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_FIN   = 3'd2;
    localparam logic [2:0] ST_TURN  = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic [CW-1:0]       k_reg;
    logic [CW-1:0]       k_next;
    logic [MAX_JOBS-1:0] served_reg;
    logic [MAX_JOBS-1:0] served_next;
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   time_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    res_t                res_reg;
    res_t                res_next;
    logic [TIME_W-1:0]   start_reg;
    logic [TIME_W-1:0]   start_next;
    logic [TIME_W-1:0]   finish_reg;
    logic [TIME_W-1:0]   finish_next;
    logic [TIME_W-1:0]   turn_reg;
    logic [TIME_W-1:0]   turn_next;
    logic                sat_reg;
    logic                sat_next;

    logic              ram_we;
    logic [EW-1:0]     ram_rdata;
    entry_t            wr_ent;
    entry_t            rd_ent;
    logic [CW-1:0]     cnt_dec;
    logic [AW-1:0]     rd_idx;
    logic              pick_clear;
    logic              pick_eval;
    logic [AW-1:0]     sel_idx;
    entry_t            sel_ent;
    logic              sel_idle;
    logic [TIME_W-1:0] pick_start;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] burst_ext;
    logic [TIME_W-1:0] wait_val;
    logic              out_free;
    logic              is_last;

    assign wr_ent     = '{arrival: cmd.arrival, burst: cmd.burst, prio: cmd.priority_req};
    assign rd_ent     = entry_t'(ram_rdata);
    assign cnt_dec    = cnt_reg - CW'(1);
    assign rd_idx     = cnt_dec[AW-1:0];
    assign pick_clear = (state_reg == ST_SCAN) && (cnt_reg == '0);
    assign pick_eval  = (state_reg == ST_SCAN) && (cnt_reg != '0);

    psch_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_JOBS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_ent),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    psch_pick #(
        .MAX_JOBS (MAX_JOBS)
    ) u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (pick_clear),
        .eval     (pick_eval),
        .idx      (rd_idx),
        .ent      (rd_ent),
        .served   (served_reg[rd_idx]),
        .now      (time_reg),
        .sel_idx  (sel_idx),
        .sel_ent  (sel_ent),
        .sel_idle (sel_idle)
    );

    assign burst_ext  = {{(TIME_W-16){1'b0}}, sel_ent.burst};
    assign pick_start = sel_idle ? {{(TIME_W-16){1'b0}}, sel_ent.arrival} : time_reg;
    assign sum        = {1'b0, pick_start} + {1'b0, burst_ext};
    assign wait_val   = (turn_reg >= burst_ext) ? (turn_reg - burst_ext) : '0;
    assign out_free   = !res_valid_reg || res_ready;
    assign is_last    = (k_reg + CW'(1)) == count_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        served_next    = served_reg;
        time_next      = time_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        start_next     = start_reg;
        finish_next    = finish_reg;
        turn_next      = turn_reg;
        sat_next       = sat_reg;
        ram_we         = 1'b0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == KIND_LOAD)
                    begin
                        if (count_reg < CW'(MAX_JOBS))
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next  = ST_SCAN;
                        cnt_next    = '0;
                        k_next      = '0;
                        time_next   = '0;
                        served_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == count_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_FIN:
            begin
                start_next  = pick_start;
                sat_next    = sum[TIME_W];
                finish_next = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                state_next  = ST_TURN;
            end
            ST_TURN:
            begin
                turn_next  = finish_reg - {{(TIME_W-16){1'b0}}, sel_ent.arrival};
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next.job_index   = 4'(sel_idx);
                    res_next.start_time  = start_reg;
                    res_next.finish_time = finish_reg;
                    res_next.turnaround  = turn_reg;
                    res_next.waiting     = wait_val;
                    res_next.idle_before = sel_idle;
                    res_next.saturated   = sat_reg;
                    res_next.table_empty = 1'b0;
                    res_next.last        = is_last;
                    served_next[sel_idx] = 1'b1;
                    time_next            = finish_reg;
                    if (is_last)
                    begin
                        state_next  = ST_IDLE;
                        count_next  = '0;
                        served_next = '0;
                        time_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                        k_next     = k_reg + CW'(1);
                        cnt_next   = '0;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next             = '0;
                    res_next.table_empty = 1'b1;
                    res_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            served_reg    <= '0;
            time_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            served_reg    <= served_next;
            time_reg      <= time_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        start_reg  <= start_next;
        finish_reg <= finish_next;
        turn_reg   <= turn_next;
        sat_reg    <= sat_next;
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_JOBS))
        else $error("job count exceeds table size");

    a_pick_unserved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> !served_reg[sel_idx])
        else $error("selected job already served");

    a_finish_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> (finish_reg >= start_reg))
        else $error("finish time before start time");

    a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH && out_free && is_last)
        |=> (count_reg == '0 && served_reg == '0 && state_reg == ST_IDLE))
        else $error("table not cleared after run");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg)
        |-> ($past(state_reg) == ST_PUSH || $past(state_reg) == ST_EMPTY))
        else $error("result raised outside result states");

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nonpreemptive_priority_scheduler: loads job tables,
// runs them and compares every result item against a built-in schedule model.
// Covers empty runs, idle gaps, tie-breaks, a full table with a dropped load,
// random job sets, random idling on both ports and output back-pressure.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import psch_pkg::*;

    localparam int JOBS        = 16;
    localparam int ITEM_TARGET = 360;

    class sched_scoreboard;

        logic [15:0] slot_arrival [JOBS];
        logic [15:0] slot_burst   [JOBS];
        logic [7:0]  slot_prio    [JOBS];
        int          stored;
        res_t        expected_service [$];
        int          errors;

        function int pick_ready(bit [JOBS-1:0] served, int unsigned now);
            int best;
            best = -1;
            for (int i = 0; i < stored; i++) begin
                if (served[i] || 32'(slot_arrival[i]) > now)
                    continue;
                if (best < 0 || slot_prio[i] < slot_prio[best] ||
                    (slot_prio[i] == slot_prio[best] &&
                     slot_arrival[i] < slot_arrival[best]))
                    best = i;
            end
            return best;
        endfunction

        function void schedule_jobs();
            bit [JOBS-1:0] served;
            int unsigned   now;
            int unsigned   t;
            int unsigned   sum;
            int unsigned   finish;
            int unsigned   turn;
            int            sel;
            res_t          r;
            if (stored == 0) begin
                r = '0;
                r.table_empty = 1'b1;
                r.last = 1'b1;
                expected_service.push_back(r);
                return;
            end
            served = '0;
            now = 0;
            for (int k = 0; k < stored; k++) begin
                r = '0;
                t = now;
                sel = pick_ready(served, t);
                if (sel < 0) begin
                    t = 32'(TIME_MAX);
                    for (int i = 0; i < stored; i++)
                        if (!served[i] && 32'(slot_arrival[i]) < t)
                            t = 32'(slot_arrival[i]);
                    r.idle_before = 1'b1;
                    sel = pick_ready(served, t);
                end
                sum = t + 32'(slot_burst[sel]);
                if (sum > 32'(TIME_MAX)) begin
                    finish = 32'(TIME_MAX);
                    r.saturated = 1'b1;
                end
                else
                begin
                    finish = sum;
                end
                turn = finish - 32'(slot_arrival[sel]);
                r.job_index   = sel[3:0];
                r.start_time  = TIME_W'(t);
                r.finish_time = TIME_W'(finish);
                r.turnaround  = TIME_W'(turn);
                r.waiting     = (turn >= 32'(slot_burst[sel])) ?
                                TIME_W'(turn - 32'(slot_burst[sel])) : '0;
                r.last        = (k == stored - 1);
                served[sel] = 1'b1;
                now = finish;
                expected_service.push_back(r);
            end
            stored = 0;
        endfunction

        function void note_command(cmd_t c);
            if (c.kind == KIND_LOAD) begin
                if (stored < JOBS) begin
                    slot_arrival[stored] = c.arrival;
                    slot_burst[stored]   = c.burst;
                    slot_prio[stored]    = c.priority_req;
                    stored++;
                end
            end
            else
            begin
                schedule_jobs();
            end
        endfunction

        function void compare_field(string name, longint unsigned want,
                                    longint unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_service.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, got %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_service.pop_front();
            compare_field("job_index",   64'(want.job_index),   64'(got.job_index));
            compare_field("start_time",  64'(want.start_time),  64'(got.start_time));
            compare_field("finish_time", 64'(want.finish_time), 64'(got.finish_time));
            compare_field("turnaround",  64'(want.turnaround),  64'(got.turnaround));
            compare_field("waiting",     64'(want.waiting),     64'(got.waiting));
            compare_field("idle_before", 64'(want.idle_before), 64'(got.idle_before));
            compare_field("saturated",   64'(want.saturated),   64'(got.saturated));
            compare_field("table_empty", 64'(want.table_empty), 64'(got.table_empty));
            compare_field("last",        64'(want.last),        64'(got.last));
        endfunction

    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic res_valid;
    logic res_ready;
    res_t res;

    sched_scoreboard sb = new;
    bit steady;
    bit hold_request;
    int items_sent;

    nonpreemptive_priority_scheduler #(
        .MAX_JOBS(JOBS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    always #4 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("nonpreemptive_priority_scheduler regression: fail");
        $finish;
    end

    function logic [15:0] random_burst();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 16'd0;
        if (sel <= 6)
            return 16'($urandom_range(0, 100));
        if (sel <= 8)
            return 16'($urandom_range(0, 5000));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_item(cmd_t c);
        while (!steady && $urandom_range(0, 99) < 30) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        items_sent++;
        sb.note_command(c);
    endtask

    task automatic load_job(logic [15:0] arrival, logic [15:0] burst, logic [7:0] prio);
        cmd_t c;
        c.kind = KIND_LOAD;
        c.arrival = arrival;
        c.burst = burst;
        c.priority_req = prio;
        send_item(c);
    endtask

    task automatic run_schedule();
        cmd_t c;
        c.kind = KIND_RUN;
        c.arrival = 16'($urandom_range(0, 65535));
        c.burst = 16'($urandom_range(0, 65535));
        c.priority_req = 8'($urandom_range(0, 255));
        send_item(c);
    endtask

    task automatic load_group(int n);
        int arr_span;
        int prio_span;
        case ($urandom_range(0, 3))
            0: arr_span = 0;
            1: arr_span = 50;
            2: arr_span = 2000;
            default: arr_span = 65535;
        endcase
        prio_span = ($urandom_range(0, 3) != 0) ? 3 : 255;
        for (int j = 0; j < n; j++)
            load_job(16'($urandom_range(0, arr_span)), random_burst(),
                     8'($urandom_range(0, prio_span)));
        run_schedule();
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_service.size() != 0);
    endtask

    initial
    begin
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            int hold_left;
            @(posedge clk);
            if (res_valid && res_ready)
                sb.check_result(res);
            if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 600;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= steady || ($urandom_range(0, 99) >= 30);
            end
        end
    end

    initial
    begin
        bit hold_done;
        bit pause_done;
        int pick;
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        cmd <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        run_schedule();

        // idle before the first job and between jobs
        load_job(16'd5, 16'd3, 8'd7);
        load_job(16'd300, 16'd4, 8'd0);
        run_schedule();

        // extremes, arrival and index tie-breaks, full table and a dropped load
        load_job(16'd0, 16'hFFFF, 8'hFF);
        load_job(16'd9, 16'd0, 8'd7);
        load_job(16'd2, 16'd0, 8'd7);
        load_job(16'd2, 16'd0, 8'd7);
        load_job(16'hFFFF, 16'd10, 8'd0);
        load_job(16'd40000, 16'hFFFF, 8'd0);
        for (int j = 0; j < 10; j++)
            load_job(16'($urandom_range(0, 65535)), random_burst(),
                     8'($urandom_range(0, 255)));
        load_job(16'd0, 16'd1, 8'd0);
        run_schedule();

        while (items_sent < ITEM_TARGET) begin
            steady = (items_sent >= 260 && items_sent < 330);
            if (!hold_done && items_sent >= 120) begin
                hold_done = 1'b1;
                hold_request = 1'b1;
                load_group(12);
                load_group(8);
            end
            else if (!pause_done && items_sent >= 220) begin
                pause_done = 1'b1;
                wait_drained();
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    run_schedule();
                else if (pick < 18)
                    load_job(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255)));
                else if (pick < 26)
                    load_group($urandom_range(14, 18));
                else
                    load_group($urandom_range(1, 8));
            end
        end
        steady = 1'b0;

        wait_drained();
        repeat (64) @(posedge clk);
        if (sb.errors == 0 && sb.expected_service.size() == 0)
            $display("nonpreemptive_priority_scheduler regression: pass");
        else
            $display("nonpreemptive_priority_scheduler regression: fail");
        $finish;
    end

endmodule
